[rtl/core/nca_pkg.sv]
// Shared types and constants for the node core first-fit allocator.
`timescale 1ns / 1ps

package nca_pkg;

    localparam int MASK_W = 16;
    localparam int COUNT_W = 5;
    localparam int NODE_W = 2;
    localparam int WIU_W = 5;
    localparam logic [WIU_W-1:0] WIU_RESET = 5'd16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic                action;
        logic [COUNT_W-1:0]  core_count;
        logic                wants_accel;
        logic [NODE_W-1:0]   release_node;
        logic [MASK_W-1:0]   release_mask;
    } nca_in_t;

    typedef struct packed {
        logic               granted;
        logic [NODE_W-1:0]  grant_node;
        logic [MASK_W-1:0]  worker_mask;
    } nca_out_t;

    typedef struct packed {
        logic load_item;
        logic capture;
        logic next_node;
        logic finish;
    } nca_cmd_t;

    typedef struct packed {
        logic is_release;
        logic qualify;
        logic last_node;
    } nca_status_t;

endpackage

[rtl/core/nca_ctrl.sv]
// Controller state machine: sequences the node scan and owns the output valid flag.
`timescale 1ns / 1ps

module nca_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  nca_pkg::nca_status_t status,
    output nca_pkg::nca_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // output slot can take a result at this edge
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.is_release)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.qualify || status.last_node)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.next_node = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result loaded while output slot still held");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken while one is in progress");

endmodule

[rtl/core/nca_dpath.sv]
// Datapath: busy bitmaps, free-worker prefix count, grant selection and result register.
`timescale 1ns / 1ps

module nca_dpath
#(
    parameter int NODES = 3,
    parameter int WORKERS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nca_pkg::WIU_W-1:0]           cfg_wdata,
    input  nca_pkg::nca_in_t                    in_data,
    input  nca_pkg::nca_cmd_t                   cmd,
    output nca_pkg::nca_status_t                status,
    output nca_pkg::nca_out_t                   out_data
);

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(WORKERS + 1);
    localparam int CMPW = (CW > nca_pkg::COUNT_W) ? CW : nca_pkg::COUNT_W;
    localparam int LEVELS = (WORKERS > 1) ? $clog2(WORKERS) : 0;

    logic [nca_pkg::WIU_W-1:0]  wiu_reg;
    nca_pkg::nca_in_t           item_reg;
    logic [NW-1:0]              idx_reg;
    logic [WORKERS-1:0]         map_reg [NODES];
    logic [NODES-1:0]           accel_reg;
    logic [WORKERS-1:0]         avail_reg;
    logic [CW-1:0]              rank_reg [WORKERS];
    nca_pkg::nca_out_t          out_reg;
    nca_pkg::nca_out_t          out_next;

    logic [WORKERS-1:0]         usable;
    logic [WORKERS-1:0]         avail;
    logic                       accel_ok;
    logic [CW-1:0]              pre [LEVELS+1][WORKERS];
    logic [WORKERS-1:0]         grant;
    logic [nca_pkg::MASK_W-1:0] grant_out;
    logic [WORKERS-1:0]         rmask_w;
    logic                       qualify;
    logic [2:0]                 rel_m1;
    logic [NW-1:0]              rel_idx;
    logic                       rel_ok;
    logic [NW:0]                node_num;

    // usable workers: the first workers_in_use, capped by the bitmap width
    for (genvar g = 0; g < WORKERS; g++)
    begin : g_usable
        assign usable[g] = (32'(g) < 32'(wiu_reg));
    end

    assign accel_ok = !(item_reg.wants_accel && accel_reg[idx_reg]);
    assign avail = ~map_reg[idx_reg] & usable & {WORKERS{accel_ok}};

    // log-depth inclusive prefix count of free workers
    for (genvar g = 0; g < WORKERS; g++)
    begin : g_pre0
        assign pre[0][g] = CW'(avail[g]);
    end

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        for (genvar g = 0; g < WORKERS; g++)
        begin : g_elem
            if (g >= (1 << l))
            begin : g_add
                assign pre[l+1][g] = pre[l][g] + pre[l][g - (1 << l)];
            end
            else
            begin : g_pass
                assign pre[l+1][g] = pre[l][g];
            end
        end
    end

    // take the lowest core_count free workers
    for (genvar g = 0; g < WORKERS; g++)
    begin : g_grant
        assign grant[g] = avail_reg[g]
                          && (CMPW'(rank_reg[g]) <= CMPW'(item_reg.core_count));
    end

    assign qualify = (item_reg.core_count != '0)
                     && (CMPW'(rank_reg[WORKERS-1]) >= CMPW'(item_reg.core_count));

    for (genvar g = 0; g < nca_pkg::MASK_W; g++)
    begin : g_gout
        if (g < WORKERS)
        begin : g_bit
            assign grant_out[g] = grant[g];
        end
        else
        begin : g_zero
            assign grant_out[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < WORKERS; g++)
    begin : g_rmask
        if (g < nca_pkg::MASK_W)
        begin : g_bit
            assign rmask_w[g] = item_reg.release_mask[g];
        end
        else
        begin : g_zero
            assign rmask_w[g] = 1'b0;
        end
    end

    assign rel_m1 = 3'(item_reg.release_node) - 3'd1;
    assign rel_idx = rel_m1[NW-1:0];
    assign rel_ok = (item_reg.release_node != '0)
                    && (32'(item_reg.release_node) <= 32'(NODES));
    assign node_num = {1'b0, idx_reg} + (NW+1)'(1);

    assign status.is_release = (item_reg.action == nca_pkg::ACT_RELEASE);
    assign status.qualify = qualify;
    assign status.last_node = (idx_reg == NW'(NODES - 1));

    always_comb
    begin
        out_next = '0;
        if (item_reg.action == nca_pkg::ACT_RELEASE)
        begin
            out_next.granted = rel_ok;
        end
        else if (qualify)
        begin
            out_next.granted = 1'b1;
            out_next.grant_node = node_num[nca_pkg::NODE_W-1:0];
            out_next.worker_mask = grant_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg <= nca_pkg::WIU_RESET;
        end
        else if (cfg_we)
        begin
            wiu_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            idx_reg <= '0;
        end
        else if (cmd.next_node)
        begin
            idx_reg <= idx_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                map_reg[n] <= '0;
            end
            accel_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (item_reg.action == nca_pkg::ACT_RELEASE)
            begin
                if (rel_ok)
                begin
                    map_reg[rel_idx] <= map_reg[rel_idx] & ~rmask_w;
                    if (item_reg.wants_accel)
                    begin
                        accel_reg[rel_idx] <= 1'b0;
                    end
                end
            end
            else if (qualify)
            begin
                map_reg[idx_reg] <= map_reg[idx_reg] | grant;
                if (item_reg.wants_accel)
                begin
                    accel_reg[idx_reg] <= 1'b1;
                end
            end
        end
    end

    // payload registers: item, per-node scan snapshot, result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.capture)
        begin
            avail_reg <= avail;
            for (int g = 0; g < WORKERS; g++)
            begin
                rank_reg[g] <= pre[LEVELS][g];
            end
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && item_reg.action == nca_pkg::ACT_ALLOC && qualify)
        |-> ((grant & map_reg[idx_reg]) == '0))
        else $error("grant covers a busy worker");

    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && item_reg.action == nca_pkg::ACT_ALLOC && qualify)
        |-> ($countones(grant) == int'(item_reg.core_count)))
        else $error("grant size differs from requested core count");

endmodule

[rtl/core/node_core_first_fit_allocator.sv]
// Allocator top level: first-fit worker and accelerator allocation over compute nodes.
// A release result loads from the check state; an allocate scans the nodes in order, a
//   check then a decide state per node, loading a grant on the first node that fits or
//   a miss after the last one. One item at a time: the next transfer is taken in the idle
//   state after the result loads; a held result stalls the load of the following one.
//   Reset clears all bitmaps and accelerator flags and sets workers_in_use to 16.
`timescale 1ns / 1ps

module node_core_first_fit_allocator
#(
    parameter int NODES = 3,
    parameter int WORKERS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nca_pkg::WIU_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  nca_pkg::nca_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output nca_pkg::nca_out_t             out_data
);

    nca_pkg::nca_cmd_t    cmd;
    nca_pkg::nca_status_t status;

    nca_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nca_dpath #(
        .NODES   (NODES),
        .WORKERS (WORKERS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

[tb/sv/node_core_first_fit_allocator_test.sv]
// Self-checking testbench for the node core first-fit allocator.
`timescale 1ns / 1ps

module node_core_first_fit_allocator_test;

    localparam int NODE_COUNT = 3;
    localparam int WORKER_COUNT = 16;
    localparam int DRAIN_CYCLES = 2 * NODE_COUNT + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 260;

    typedef struct {
        logic [nca_pkg::NODE_W-1:0] node;
        logic [nca_pkg::MASK_W-1:0] mask;
        logic                       accel;
    } grant_rec_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [nca_pkg::WIU_W-1:0]   cfg_wdata = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    nca_pkg::nca_in_t            in_data = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    nca_pkg::nca_out_t           out_data;

    // Shadow of the allocator state
    logic [nca_pkg::MASK_W-1:0]  busy_map [1:NODE_COUNT];
    logic                        accel_busy [1:NODE_COUNT];
    logic [nca_pkg::WIU_W-1:0]   worker_limit;

    nca_pkg::nca_out_t           expected_grants [$];
    grant_rec_t                  live_grants [$];

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 grant_count = 0;
    int                 miss_count = 0;
    int                 release_count = 0;

    node_core_first_fit_allocator
    #(
        .NODES   (NODE_COUNT),
        .WORKERS (WORKER_COUNT)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_grants.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic nca_pkg::nca_out_t predict_allocation(input nca_pkg::nca_in_t item);
        nca_pkg::nca_out_t          res;
        logic [nca_pkg::MASK_W-1:0] usable;
        logic [nca_pkg::MASK_W-1:0] free_w;
        logic [nca_pkg::MASK_W-1:0] pick;
        int                         limit;
        int                         taken;
        res = '0;
        if (item.action == nca_pkg::ACT_RELEASE)
        begin
            if (item.release_node != 0 && item.release_node <= NODE_COUNT)
            begin
                busy_map[item.release_node] &= ~item.release_mask;
                if (item.wants_accel)
                    accel_busy[item.release_node] = 1'b0;
                res.granted = 1'b1;
            end
            return res;
        end
        limit = (worker_limit > WORKER_COUNT) ? WORKER_COUNT : worker_limit;
        usable = '0;
        for (int i = 0; i < limit; i++)
            usable[i] = 1'b1;
        if (item.core_count == 0)
            return res;
        for (int n = 1; n <= NODE_COUNT; n++)
        begin
            if (item.wants_accel && accel_busy[n])
                continue;
            free_w = ~busy_map[n] & usable;
            if ($countones(free_w) < item.core_count)
                continue;
            pick = '0;
            taken = 0;
            for (int i = 0; i < WORKER_COUNT; i++)
            begin
                if (free_w[i] && taken < item.core_count)
                begin
                    pick[i] = 1'b1;
                    taken++;
                end
            end
            busy_map[n] |= pick;
            if (item.wants_accel)
                accel_busy[n] = 1'b1;
            res.granted = 1'b1;
            res.grant_node = nca_pkg::NODE_W'(n);
            res.worker_mask = pick;
            return res;
        end
        return res;
    endfunction

    // Unused fields get random content; the block must ignore them.
    function automatic nca_pkg::nca_in_t make_alloc(input int cores, input logic accel);
        nca_pkg::nca_in_t item;
        item.action = nca_pkg::ACT_ALLOC;
        item.core_count = nca_pkg::COUNT_W'(cores);
        item.wants_accel = accel;
        item.release_node = nca_pkg::NODE_W'($urandom_range(3, 0));
        item.release_mask = nca_pkg::MASK_W'($urandom);
        return item;
    endfunction

    function automatic nca_pkg::nca_in_t make_release(input int node,
                                                      input logic [nca_pkg::MASK_W-1:0] mask,
                                                      input logic accel);
        nca_pkg::nca_in_t item;
        item.action = nca_pkg::ACT_RELEASE;
        item.core_count = nca_pkg::COUNT_W'($urandom_range(31, 0));
        item.wants_accel = accel;
        item.release_node = nca_pkg::NODE_W'(node);
        item.release_mask = mask;
        return item;
    endfunction

    function automatic nca_pkg::nca_in_t random_item();
        int         pick;
        int         cores;
        int         idx;
        grant_rec_t rec;
        pick = $urandom_range(99, 0);
        if (pick >= 55 && pick < 90 && live_grants.size() > 0)
        begin
            idx = $urandom_range(live_grants.size() - 1, 0);
            rec = live_grants[idx];
            live_grants.delete(idx);
            // mostly the matching accel flag, now and then the wrong one
            if ($urandom_range(9, 0) == 0)
                rec.accel = ~rec.accel;
            return make_release(rec.node, rec.mask, rec.accel);
        end
        if (pick >= 90)
            return make_release($urandom_range(3, 0), nca_pkg::MASK_W'($urandom),
                                1'($urandom_range(1, 0)));
        pick = $urandom_range(99, 0);
        if (pick < 80)
            cores = $urandom_range(4, 1);
        else if (pick < 95)
            cores = $urandom_range(WORKER_COUNT, 5);
        else if (pick < 97)
            cores = 0;
        else
            cores = $urandom_range(31, WORKER_COUNT + 1);
        return make_alloc(cores, $urandom_range(99, 0) < 30);
    endfunction

    task automatic send_item(input nca_pkg::nca_in_t item);
        nca_pkg::nca_out_t res;
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        // transfer taken at this edge
        res = predict_allocation(item);
        expected_grants.push_back(res);
        items_sent++;
        if (item.action == nca_pkg::ACT_RELEASE)
            release_count++;
        else if (res.granted)
        begin
            grant_count++;
            live_grants.push_back('{res.grant_node, res.worker_mask, item.wants_accel});
        end
        else
            miss_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_worker_limit(input logic [nca_pkg::WIU_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        worker_limit = value;
    endtask

    task automatic release_everything();
        for (int n = 1; n <= NODE_COUNT; n++)
            send_item(make_release(n, '1, 1'b1));
        live_grants.delete();
    endtask

    task automatic compare_field(input string name, input logic [nca_pkg::MASK_W-1:0] want,
                                 input logic [nca_pkg::MASK_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        nca_pkg::nca_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                compare_field("granted", nca_pkg::MASK_W'(want.granted),
                              nca_pkg::MASK_W'(out_data.granted));
                compare_field("grant_node", nca_pkg::MASK_W'(want.grant_node),
                              nca_pkg::MASK_W'(out_data.grant_node));
                compare_field("worker_mask", want.worker_mask, out_data.worker_mask);
                results_checked++;
            end
        end
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic test_directed_cases();
        send_item(make_alloc(1, 1'b0));
        send_item(make_alloc(WORKER_COUNT - 1, 1'b0));
        send_item(make_alloc(WORKER_COUNT, 1'b1));
        send_item(make_alloc(WORKER_COUNT, 1'b1));
        // every node full: no node fits
        send_item(make_alloc(1, 1'b0));
        send_item(make_alloc(0, 1'b0));
        send_item(make_alloc(31, 1'b0));
        // release to node 0 is dropped
        send_item(make_release(0, '1, 1'b1));
        send_item(make_release(2, '1, 1'b0));
        // node 2 has workers but its accelerator is still held
        send_item(make_alloc(4, 1'b1));
        send_item(make_alloc(4, 1'b0));
        send_item(make_release(2, '0, 1'b1));
        send_item(make_alloc(2, 1'b1));
        send_item(make_release(3, 16'haaaa, 1'b1));
        // freeing what is already free changes nothing
        send_item(make_release(3, 16'haaaa, 1'b1));
        send_item(make_alloc(8, 1'b1));
        release_everything();
        send_item(make_alloc(WORKER_COUNT, 1'b0));
        send_item(make_release(1, 16'h5555, 1'b0));
        release_everything();
    endtask

    task automatic test_worker_limit();
        wait_idle();
        write_worker_limit('0);
        send_item(make_alloc(1, 1'b0));
        send_item(make_alloc(0, 1'b1));
        wait_idle();
        write_worker_limit(5'd1);
        send_item(make_alloc(1, 1'b0));
        send_item(make_alloc(2, 1'b0));
        send_item(make_alloc(1, 1'b1));
        release_everything();
        wait_idle();
        // above the worker count: saturate
        write_worker_limit('1);
        send_item(make_alloc(WORKER_COUNT, 1'b0));
        send_item(make_alloc(WORKER_COUNT + 1, 1'b0));
        wait_idle();
        write_worker_limit(5'd17);
        send_item(make_alloc(WORKER_COUNT, 1'b1));
        release_everything();
        wait_idle();
        write_worker_limit(5'd10);
        send_item(make_alloc(10, 1'b0));
        send_item(make_alloc(11, 1'b0));
        send_item(make_alloc(3, 1'b0));
        release_everything();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [nca_pkg::WIU_W-1:0] limit_value);
        wait_idle();
        write_worker_limit(limit_value);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (RANDOM_ITEMS) send_item(random_item());
    endtask

    initial
    begin
        worker_limit = nca_pkg::WIU_RESET;
        for (int n = 1; n <= NODE_COUNT; n++)
        begin
            busy_map[n] = '0;
            accel_busy[n] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_stall_pct = 83;
        test_directed_cases();
        test_worker_limit();
        test_random_traffic(22, 83, nca_pkg::WIU_RESET);
        test_random_traffic(83, 22, nca_pkg::WIU_W'($urandom_range(15, 4)));
        test_random_traffic(0, 0, '1);
        wait_idle();
        $display("Checked %0d of %0d requests: %0d grants, %0d misses, %0d releases",
                 results_checked, items_sent, grant_count, miss_count, release_count);
        $display("Worker limits from zero to above the worker count, three idle mixes");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[node_core_first_fit_allocator.f]
rtl/core/nca_pkg.sv
rtl/core/nca_ctrl.sv
rtl/core/nca_dpath.sv
rtl/core/node_core_first_fit_allocator.sv
tb/sv/node_core_first_fit_allocator_test.sv
